@@ rtl/core/palette_pixel_downscaler_core_assert.svh @@
// Assertion macros shared by the downscaler RTL.
`ifndef PALETTE_PIXEL_DOWNSCALER_CORE_ASSERT_SVH
`define PALETTE_PIXEL_DOWNSCALER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppd assertion failed");

// Next-cycle implication, checked outside reset.
`define PPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppd assertion failed");

`endif

@@ rtl/core/ppd_pkg.sv @@
// Package: constants, types and helpers of the palette pixel downscaler.
`timescale 1ns / 1ps

package ppd_pkg;

   localparam int SRC_WIDTH    = 320;
   localparam int SRC_HEIGHT   = 200;
   localparam int GAMMA_LEVELS = 5;

   localparam int COL_W = $clog2(SRC_WIDTH);
   localparam int ROW_W = $clog2(SRC_HEIGHT);

   localparam int LAST_EVEN_COL = (SRC_WIDTH - 1) & ~1;
   localparam int LAST_EVEN_ROW = (SRC_HEIGHT - 1) & ~1;

   localparam int GAMMA_DEPTH = GAMMA_LEVELS * 256;
   localparam int GAMMA_AW    = $clog2(GAMMA_DEPTH);
   localparam int PAL_DEPTH   = 256;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   // request commands
   localparam logic [1:0] CMD_PIXEL   = 2'd0;
   localparam logic [1:0] CMD_PALETTE = 2'd1;
   localparam logic [1:0] CMD_GAMMA   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_LEVEL = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_VERT_OFFSET = CSR_INDEX_W'(1);

   localparam logic [4:0] VERT_OFFSET_RESET = 5'd14;

   typedef struct packed {
      logic       emit;
      logic [7:0] out_x;
      logic [6:0] out_y;
      logic       line_end;
      logic       frame_end;
   } raster_info_type;

   // curve level and component value to a flat gamma table address
   function automatic logic [GAMMA_AW-1:0] gamma_addr(input logic [2:0] level,
                                                      input logic [7:0] value);
      return GAMMA_AW'({level, value});
   endfunction

   function automatic logic [2:0] sat_level(input logic [2:0] level);
      if (int'(level) >= GAMMA_LEVELS) begin
         return 3'(GAMMA_LEVELS - 1);
      end
      return level;
   endfunction

   function automatic logic [15:0] pack_565(input logic [7:0] r,
                                            input logic [7:0] g,
                                            input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

@@ rtl/core/ppd_req_if.sv @@
// Request channel: command item with palette, gamma and pixel fields.
`timescale 1ns / 1ps

interface ppd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] color_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [2:0] curve_select;
   logic [7:0] curve_input;
   logic [7:0] curve_output;

   modport source (output valid, cmd, color_index, red, green, blue,
                   curve_select, curve_input, curve_output, input ready);
   modport sink   (input valid, cmd, color_index, red, green, blue,
                   curve_select, curve_input, curve_output, output ready);
endinterface

@@ rtl/core/ppd_rsp_if.sv @@
// Response channel: one downscaled RGB565 pixel with its position.
`timescale 1ns / 1ps

interface ppd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_x;
   logic [6:0]  out_y;
   logic [15:0] color;
   logic        line_end;
   logic        frame_end;

   modport source (output valid, out_x, out_y, color, line_end, frame_end,
                   input ready);
   modport sink   (input valid, out_x, out_y, color, line_end, frame_end,
                   output ready);
endinterface

@@ rtl/core/ppd_csr_if.sv @@
// Register write channel: index and data.
`timescale 1ns / 1ps

interface ppd_csr_if;
   import ppd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/ppd_gamma_mem.sv @@
// Gamma tables: one copy per color lane, shared write, one read per lane.
`timescale 1ns / 1ps

module ppd_gamma_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ppd_pkg::GAMMA_AW-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic [ppd_pkg::GAMMA_AW-1:0] rd_addr_r,
   input  logic [ppd_pkg::GAMMA_AW-1:0] rd_addr_g,
   input  logic [ppd_pkg::GAMMA_AW-1:0] rd_addr_b,
   output logic [7:0]                   rd_data_r,
   output logic [7:0]                   rd_data_g,
   output logic [7:0]                   rd_data_b
);
   import ppd_pkg::*;

   logic [7:0] mem_r [GAMMA_DEPTH];
   logic [7:0] mem_g [GAMMA_DEPTH];
   logic [7:0] mem_b [GAMMA_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_r[wr_addr] <= wr_data;
         mem_g[wr_addr] <= wr_data;
         mem_b[wr_addr] <= wr_data;
      end
   end

   // read data holds while no palette write is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_r <= mem_r[rd_addr_r];
         rd_data_g <= mem_g[rd_addr_g];
         rd_data_b <= mem_b[rd_addr_b];
      end
   end

endmodule

@@ rtl/core/ppd_palette_mem.sv @@
// Palette RAM: 256 RGB565 entries, one write and one registered read.
`timescale 1ns / 1ps

module ppd_palette_mem (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_addr,
   input  logic [15:0] wr_data,
   input  logic        rd_en,
   input  logic [7:0]  rd_addr,
   output logic [15:0] rd_data
);
   import ppd_pkg::*;

   logic [15:0] mem [PAL_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-during-write returns old data; the pipeline forwards around it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/core/ppd_raster.sv @@
// Source raster position counters and the 2x decimation decision.
`timescale 1ns / 1ps

module ppd_raster (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [4:0]               vert_offset,
   output ppd_pkg::raster_info_type info
);
   import ppd_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             lend;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_ff == COL_W'(SRC_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff == ROW_W'(SRC_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign lend = (col_ff == COL_W'(LAST_EVEN_COL));

   always_comb begin
      info.emit      = !col_ff[0] && !row_ff[0];
      info.out_x     = 8'(col_ff >> 1);
      info.out_y     = 7'(row_ff >> 1) + 7'(vert_offset);
      info.line_end  = lend;
      info.frame_end = lend && (row_ff == ROW_W'(LAST_EVEN_ROW));
   end

endmodule

@@ rtl/core/palette_pixel_downscaler_core.sv @@
// Top level: request decode, table pipeline and response register.
// Takes one request per clock. A gamma write lands in the gamma tables at
// acceptance; a palette write reads the three gamma lanes in that cycle and
// writes the packed RGB565 word into the palette RAM on the next clock. A
// pixel reads the palette RAM at acceptance (registered read, with forwarding
// from a palette write landing in the same cycle) and waits in stage 1 until
// the output register is empty or being taken; then its response is loaded
// into the output register. Requests stall only while a pixel waits in
// stage 1 behind a response that has not been taken.
// Pixels on odd columns or odd rows advance the raster but give no
// response. The tables need no clearing pass; they are valid once written.
// Register writes are always ready and should be made while idle.
`timescale 1ns / 1ps
`include "palette_pixel_downscaler_core_assert.svh"

module palette_pixel_downscaler_core (
   input  logic  clock,
   input  logic  reset,
   ppd_req_if.sink   req_chan,
   ppd_rsp_if.source rsp_chan,
   ppd_csr_if.sink   csr_chan
);
   import ppd_pkg::*;

   logic                  req_accept;
   logic                  is_pixel, is_palette, is_gamma;
   logic [2:0]            gamma_level_ff;
   logic [4:0]            vert_offset_ff;
   raster_info_type       info;

   logic [7:0]            g_r, g_g, g_b;
   logic [2:0]            rd_level;
   logic [15:0]           pal_rdata;
   logic [15:0]           pal_wdata;

   // stage 1: palette write waiting for gamma data
   logic                  s1_pw_ff, s1_pw_in;
   logic [7:0]            s1_pw_idx_ff;
   // stage 1: pixel waiting for palette data
   logic                  s1_pix_ff, s1_pix_in;
   logic [7:0]            s1_x_ff;
   logic [6:0]            s1_y_ff;
   logic                  s1_lend_ff, s1_fend_ff;
   logic                  s1_fwd_ff;
   logic [15:0]           s1_fwd_data_ff;
   logic [15:0]           s1_color;

   logic                  s1_move;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_x_ff;
   logic [6:0]            out_y_ff;
   logic [15:0]           out_color_ff;
   logic                  out_lend_ff, out_fend_ff;

   // register port
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_level_ff <= '0;
         vert_offset_ff <= VERT_OFFSET_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_GAMMA_LEVEL: gamma_level_ff <= csr_chan.data[2:0];
            CSR_VERT_OFFSET: vert_offset_ff <= csr_chan.data[4:0];
            default: ;
         endcase
      end
   end

   // request decode
   assign s1_move      = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_pix_ff || s1_move;
   assign req_accept   = req_chan.valid && req_chan.ready;
   assign is_pixel     = (req_chan.cmd == CMD_PIXEL);
   assign is_palette   = (req_chan.cmd == CMD_PALETTE);
   assign is_gamma     = (req_chan.cmd == CMD_GAMMA);
   assign rd_level     = sat_level(gamma_level_ff);

   ppd_raster u_raster (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_accept && is_pixel),
      .vert_offset (vert_offset_ff),
      .info        (info)
   );

   ppd_gamma_mem u_gamma (
      .clock     (clock),
      .wr_en     (req_accept && is_gamma && (int'(req_chan.curve_select) < GAMMA_LEVELS)),
      .wr_addr   (gamma_addr(req_chan.curve_select, req_chan.curve_input)),
      .wr_data   (req_chan.curve_output),
      .rd_en     (req_accept && is_palette),
      .rd_addr_r (gamma_addr(rd_level, req_chan.red)),
      .rd_addr_g (gamma_addr(rd_level, req_chan.green)),
      .rd_addr_b (gamma_addr(rd_level, req_chan.blue)),
      .rd_data_r (g_r),
      .rd_data_g (g_g),
      .rd_data_b (g_b)
   );

   assign pal_wdata = pack_565(g_r, g_g, g_b);

   ppd_palette_mem u_palette (
      .clock   (clock),
      .wr_en   (s1_pw_ff),
      .wr_addr (s1_pw_idx_ff),
      .wr_data (pal_wdata),
      .rd_en   (req_accept && is_pixel),
      .rd_addr (req_chan.color_index),
      .rd_data (pal_rdata)
   );

   // stage 1 control
   assign s1_pw_in  = req_accept && is_palette;
   assign s1_pix_in = req_accept ? (is_pixel && info.emit) : (s1_pix_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pw_ff  <= 1'b0;
         s1_pix_ff <= 1'b0;
      end else begin
         s1_pw_ff  <= s1_pw_in;
         s1_pix_ff <= s1_pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_pw_in) begin
         s1_pw_idx_ff <= req_chan.color_index;
      end
      if (req_accept && is_pixel) begin
         s1_x_ff        <= info.out_x;
         s1_y_ff        <= info.out_y;
         s1_lend_ff     <= info.line_end;
         s1_fend_ff     <= info.frame_end;
         // palette write landing on this edge is missed by the RAM read
         s1_fwd_ff      <= s1_pw_ff && (s1_pw_idx_ff == req_chan.color_index);
         s1_fwd_data_ff <= pal_wdata;
      end
   end

   assign s1_color = s1_fwd_ff ? s1_fwd_data_ff : pal_rdata;

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_pix_ff) begin
         out_x_ff     <= s1_x_ff;
         out_y_ff     <= s1_y_ff;
         out_color_ff <= s1_color;
         out_lend_ff  <= s1_lend_ff;
         out_fend_ff  <= s1_fend_ff;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_x     = out_x_ff;
   assign rsp_chan.out_y     = out_y_ff;
   assign rsp_chan.color     = out_color_ff;
   assign rsp_chan.line_end  = out_lend_ff;
   assign rsp_chan.frame_end = out_fend_ff;

   `PPD_ASSERT_NOW(a_stall_blocks_req, clock, reset,
      s1_pix_ff && out_valid_ff && !rsp_chan.ready, !req_chan.ready)
   `PPD_ASSERT_NEXT(a_palette_write_lands, clock, reset,
      req_chan.valid && req_chan.ready && (req_chan.cmd == CMD_PALETTE), s1_pw_ff)
   `PPD_ASSERT_NOW(a_frame_end_on_line_end, clock, reset,
      out_valid_ff && out_fend_ff, out_lend_ff)
   `PPD_ASSERT_NOW(a_out_x_in_range, clock, reset,
      out_valid_ff, out_x_ff <= 8'(LAST_EVEN_COL >> 1))

endmodule

@@ bench/palette_pixel_downscaler_core_tb.sv @@
// Testbench for palette_pixel_downscaler_core: random and directed requests against a predictor.
`timescale 1ns / 1ps

module palette_pixel_downscaler_core_tb;
   import ppd_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CURVE_CODES   = 8;
   localparam int MAX_GAP       = 11;
   localparam int DRAIN_CYCLES  = 4;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 50;
   localparam int SWEEP_CHUNKS  = 4;
   localparam int SWEEP_PIXELS  = SRC_WIDTH + 8;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] curve_select;
      logic [7:0] curve_input;
      logic [7:0] curve_output;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_x;
      logic [6:0]  out_y;
      logic [15:0] color;
      logic        line_end;
      logic        frame_end;
   } pixel_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } reg_write_type;

   class raster_scoreboard_type;
      logic [7:0]       curve_tab [GAMMA_LEVELS][256];
      logic [15:0]      palette_tab [PAL_DEPTH];
      bit               curve_set [GAMMA_LEVELS][256];
      logic [7:0]       curve_known [GAMMA_LEVELS][256];
      int               curve_count [GAMMA_LEVELS];
      bit               pal_set [PAL_DEPTH];
      logic [7:0]       pal_known [PAL_DEPTH];
      int               pal_count;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [2:0]       gamma_level;
      logic [4:0]       vert_offset;
      pixel_type        expected_pixels [$];
      int               mismatches;

      function new();
         col = '0;
         row = '0;
         gamma_level = 3'd0;
         vert_offset = VERT_OFFSET_RESET;
         pal_count = 0;
         mismatches = 0;
         foreach (curve_count[i]) curve_count[i] = 0;
      endfunction

      function void set_register(reg_write_type w);
         if (w.index == CSR_GAMMA_LEVEL) begin
            gamma_level = w.data[2:0];
         end else if (w.index == CSR_VERT_OFFSET) begin
            vert_offset = w.data[4:0];
         end
      endfunction

      // levels past the last curve fall back to the last one
      function logic [2:0] active_curve();
         return (int'(gamma_level) >= GAMMA_LEVELS) ? 3'(GAMMA_LEVELS - 1) : gamma_level;
      endfunction

      function void note_request(req_item_type it);
         logic [2:0] c;
         logic [7:0] r, g, b;
         pixel_type  px;
         case (it.cmd)
            CMD_GAMMA: begin
               c = it.curve_select;
               if (int'(c) < GAMMA_LEVELS) begin
                  curve_tab[c][it.curve_input] = it.curve_output;
                  if (!curve_set[c][it.curve_input]) begin
                     curve_set[c][it.curve_input] = 1'b1;
                     curve_known[c][curve_count[c]] = it.curve_input;
                     curve_count[c] = curve_count[c] + 1;
                  end
               end
            end
            CMD_PALETTE: begin
               c = active_curve();
               r = curve_tab[c][it.red];
               g = curve_tab[c][it.green];
               b = curve_tab[c][it.blue];
               palette_tab[it.color_index] = {r[7:3], g[7:2], b[7:3]};
               if (!pal_set[it.color_index]) begin
                  pal_set[it.color_index] = 1'b1;
                  pal_known[pal_count] = it.color_index;
                  pal_count = pal_count + 1;
               end
            end
            CMD_PIXEL: begin
               if (!col[0] && !row[0]) begin
                  px.out_x = 8'(col >> 1);
                  px.out_y = 7'((row >> 1) + vert_offset);
                  px.color = palette_tab[it.color_index];
                  px.line_end = (int'(col) == LAST_EVEN_COL);
                  px.frame_end = px.line_end && (int'(row) == LAST_EVEN_ROW);
                  expected_pixels.push_back(px);
               end
               if (int'(col) == SRC_WIDTH - 1) begin
                  col = '0;
                  row = (int'(row) == SRC_HEIGHT - 1) ? '0 : row + 1'b1;
               end else begin
                  col = col + 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel: x=%0d y=%0d color=%h line_end=%b frame_end=%b",
                        got.out_x, got.out_y, got.color, got.line_end, got.frame_end);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
             got.color !== want.color || got.line_end !== want.line_end ||
             got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected x=%0d y=%0d color=%h le=%b fe=%b, %s",
                        want.out_x, want.out_y, want.color, want.line_end, want.frame_end,
                        $sformatf("got x=%0d y=%0d color=%h le=%b fe=%b", got.out_x,
                                  got.out_y, got.color, got.line_end, got.frame_end));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   req_quiet;
   bit   rsp_quiet;
   int   rsp_hold;
   raster_scoreboard_type board;

   ppd_req_if req_bus ();
   ppd_rsp_if rsp_bus ();
   ppd_csr_if csr_bus ();

   palette_pixel_downscaler_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic req_item_type blank_item(logic [1:0] cmd);
      req_item_type it;
      it.cmd = cmd;
      it.color_index = 8'($urandom);
      it.red = 8'($urandom);
      it.green = 8'($urandom);
      it.blue = 8'($urandom);
      it.curve_select = 3'($urandom);
      it.curve_input = 8'($urandom);
      it.curve_output = 8'($urandom);
      return it;
   endfunction

   function automatic req_item_type gamma_item(logic [2:0] c, logic [7:0] x, logic [7:0] y);
      req_item_type it;
      it = blank_item(CMD_GAMMA);
      it.curve_select = c;
      it.curve_input = x;
      it.curve_output = y;
      return it;
   endfunction

   function automatic req_item_type palette_item(logic [7:0] idx, logic [7:0] r,
                                                 logic [7:0] g, logic [7:0] b);
      req_item_type it;
      it = blank_item(CMD_PALETTE);
      it.color_index = idx;
      it.red = r;
      it.green = g;
      it.blue = b;
      return it;
   endfunction

   function automatic req_item_type pixel_item(logic [7:0] idx);
      req_item_type it;
      it = blank_item(CMD_PIXEL);
      it.color_index = idx;
      return it;
   endfunction

   // pixels only ever look up palette entries that were written
   function automatic req_item_type random_pixel();
      return pixel_item(board.pal_known[$urandom_range(0, board.pal_count - 1)]);
   endfunction

   function automatic logic [7:0] known_input(logic [2:0] c);
      return board.curve_known[c][$urandom_range(0, board.curve_count[c] - 1)];
   endfunction

   function automatic req_item_type random_item();
      int         pick;
      logic [2:0] c;
      pick = $urandom_range(0, 99);
      c = board.active_curve();
      if (pick >= 45 && board.pal_count == 0) pick = 30;
      if (pick >= 25 && pick < 45 && board.curve_count[c] == 0)
         return gamma_item(c, 8'($urandom), 8'($urandom));
      if (pick < 6) return blank_item(CMD_UNUSED);
      if (pick < 25) begin
         if ($urandom_range(0, 15) == 0)
            c = 3'($urandom_range(GAMMA_LEVELS, CURVE_CODES - 1));
         else
            c = 3'($urandom_range(0, GAMMA_LEVELS - 1));
         return gamma_item(c, 8'($urandom), 8'($urandom));
      end
      if (pick < 45)
         return palette_item(8'($urandom), known_input(c), known_input(c), known_input(c));
      return random_pixel();
   endfunction

   task automatic send_request(input req_item_type it, input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= it.cmd;
      req_bus.color_index <= it.color_index;
      req_bus.red <= it.red;
      req_bus.green <= it.green;
      req_bus.blue <= it.blue;
      req_bus.curve_select <= it.curve_select;
      req_bus.curve_input <= it.curve_input;
      req_bus.curve_output <= it.curve_output;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(it);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.expected_pixels.size() != 0);
   endtask

   task automatic write_regs(input reg_write_type wr [$]);
      foreach (wr[i]) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= wr[i].index;
         csr_bus.data <= wr[i].data;
         do @(posedge clock); while (!csr_bus.ready);
         board.set_register(wr[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // odd pixels give no response, so allow the pipeline to empty past the last one
   task automatic reconfigure(input logic [2:0] level, input logic [4:0] offset,
                              input bit spare);
      reg_write_type wr [$];
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      wr.push_back({CSR_GAMMA_LEVEL, {5'($urandom), level}});
      wr.push_back({CSR_VERT_OFFSET, {3'($urandom), offset}});
      if (spare || $urandom_range(0, 1) == 0)
         wr.push_back({CSR_INDEX_W'($urandom_range(int'(CSR_VERT_OFFSET) + 1,
                                                   2**CSR_INDEX_W - 1)),
                       CSR_DATA_W'($urandom)});
      write_regs(wr);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         board.check_pixel({rsp_bus.out_x, rsp_bus.out_y, rsp_bus.color,
                            rsp_bus.line_end, rsp_bus.frame_end});
         rsp_hold = pick_gap(rsp_quiet);
         rsp_bus.ready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_bus.ready <= (rsp_hold == 0);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      board = new();
      reset = 1'b1;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_PIXEL;
      req_bus.color_index = '0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.curve_select = '0;
      req_bus.curve_input = '0;
      req_bus.curve_output = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_GAMMA_LEVEL;
      csr_bus.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // curve extremes; writes to curves past the last one must be dropped
      send_request(gamma_item(3'd0, 8'd0, 8'd0), pick_gap(1'b0));
      send_request(gamma_item(3'd0, 8'd255, 8'd255), pick_gap(1'b0));
      send_request(gamma_item(3'd0, 8'd128, 8'hA5), pick_gap(1'b0));
      send_request(gamma_item(3'd7, 8'd0, 8'h5A), pick_gap(1'b0));
      send_request(gamma_item(3'(GAMMA_LEVELS), 8'd255, 8'd0), pick_gap(1'b0));
      send_request(gamma_item(3'(GAMMA_LEVELS - 1), 8'd0, 8'd255), pick_gap(1'b0));
      send_request(gamma_item(3'(GAMMA_LEVELS - 1), 8'd255, 8'd0), pick_gap(1'b0));
      send_request(palette_item(8'd0, 8'd255, 8'd255, 8'd255), pick_gap(1'b0));
      send_request(palette_item(8'd255, 8'd0, 8'd0, 8'd0), pick_gap(1'b0));
      send_request(palette_item(8'd128, 8'd128, 8'd0, 8'd255), pick_gap(1'b0));
      send_request(pixel_item(8'd0), pick_gap(1'b0));
      send_request(pixel_item(8'd255), pick_gap(1'b0));
      send_request(blank_item(CMD_UNUSED), pick_gap(1'b0));
      send_request(pixel_item(8'd128), pick_gap(1'b0));
      send_request(pixel_item(8'd0), pick_gap(1'b0));
      // pixel right behind the palette write of its own entry
      send_request(palette_item(8'd1, 8'd0, 8'd255, 8'd128), pick_gap(1'b0));
      send_request(pixel_item(8'd1), 0);
      // out-of-range level saturates to the last curve
      reconfigure(3'd7, 5'd0, 1'b1);
      send_request(palette_item(8'd2, 8'd0, 8'd255, 8'd0), pick_gap(1'b0));
      send_request(pixel_item(8'd0), pick_gap(1'b0));
      send_request(pixel_item(8'd2), 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         reconfigure(3'(p), (p == 0) ? 5'd0 : (p == 1) ? 5'd28 : (p == 2) ? 5'd31 :
                     5'($urandom), p == 0);
         req_quiet = (p % 3 == 2);
         rsp_quiet = req_quiet;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 63) == 0) wait_drained();
            send_request(random_item(), pick_gap(req_quiet));
         end
      end

      // a source line and a bit more, to reach line end and the row advance
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      for (int s = 0; s < SWEEP_CHUNKS; s++) begin
         reconfigure(3'($urandom), (s == 0) ? 5'd31 : 5'($urandom), 1'b0);
         for (int n = 0; n < SWEEP_PIXELS / SWEEP_CHUNKS; n++)
            send_request(random_pixel(),
                         ($urandom_range(0, 15) == 0) ? $urandom_range(1, MAX_GAP) : 0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
